[sv/mpo_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpo_pkg: shared definitions for the multiwave phase oscillator
// Operation and shape codes, register indexes, default parameters and the
// structs that pass between the front end, word queue and back end.
// ----------------------------------------------------------------------------
package mpo_pkg;

    localparam int DEF_TABLE_DEPTH        = 2048;
    localparam int DEF_SINE_QUARTER_DEPTH = 1024;
    localparam int DEF_MAX_CHANNELS       = 8;
    localparam int DEF_PHASE_BITS         = 32;

    localparam int QUEUE_DEPTH = 2;

    // quarter-wave table generation, Q30 Taylor series
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_LOAD  = 2'd3
    } op_t;

    localparam logic [2:0] SHAPE_SINE     = 3'd0;
    localparam logic [2:0] SHAPE_SQUARE   = 3'd1;
    localparam logic [2:0] SHAPE_SAWTOOTH = 3'd2;
    localparam logic [2:0] SHAPE_TRIANGLE = 3'd3;
    localparam logic [2:0] SHAPE_CUSTOM   = 3'd4;

    localparam logic [1:0] REG_WAVE_SHAPE    = 2'd0;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
    localparam logic [1:0] REG_TABLE_SIZE    = 2'd2;

    typedef struct packed {
        logic [2:0]  wave_shape;
        logic [3:0]  channel_count;
        logic [11:0] table_size;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic signed [15:0] sample;
    } q_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

[sv/multiwave_phase_oscillator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiwave_phase_oscillator_unit: phase-accumulator oscillator, top level
// A running frame tick steps through multiply, table read, multiply-accumulate
// and sum before its sample is pushed; a stopped tick pushes a zero sample.
// The front end takes no new word until its six-step sample sequence is done,
// and the fan-out sends one word a cycle while m_tready is high.
// Reset clears phase, run flag and queue and presets the registers; wavetable not reset.
// ----------------------------------------------------------------------------
module multiwave_phase_oscillator_unit #(
    parameter int TABLE_DEPTH        = mpo_pkg::DEF_TABLE_DEPTH,
    parameter int SINE_QUARTER_DEPTH = mpo_pkg::DEF_SINE_QUARTER_DEPTH,
    parameter int MAX_CHANNELS       = mpo_pkg::DEF_MAX_CHANNELS,
    parameter int PHASE_BITS         = mpo_pkg::DEF_PHASE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_addr,
    input  logic [11:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // phase_step[31:0], table_index[42:32], table_value[58:43]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // sample_value[15:0], channel_index[18:16]
    output logic        m_tlast    // last_of_frame
);
    import mpo_pkg::*;

    cfg_t               cfg_reg;
    q_push_t            push;
    q_stat_t            q_stat;
    logic               pop;
    logic signed [15:0] rd_sample;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wave_shape    <= SHAPE_SINE;
            cfg_reg.channel_count <= 4'd1;
            cfg_reg.table_size    <= 12'd0;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                REG_WAVE_SHAPE:    cfg_reg.wave_shape    <= cfg_wdata[2:0];
                REG_CHANNEL_COUNT: cfg_reg.channel_count <= cfg_wdata[3:0];
                REG_TABLE_SIZE:    cfg_reg.table_size    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    mpo_front #(
        .TABLE_DEPTH        (TABLE_DEPTH),
        .SINE_QUARTER_DEPTH (SINE_QUARTER_DEPTH),
        .PHASE_BITS         (PHASE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .operation   (op_t'(s_tuser)),
        .phase_step  (s_tdata[31:0]),
        .table_index (s_tdata[42:32]),
        .table_value ($signed(s_tdata[58:43])),
        .push        (push),
        .q_stat      (q_stat)
    );

    mpo_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .q_stat    (q_stat),
        .rd_sample (rd_sample)
    );

    mpo_back #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_stat    (q_stat),
        .rd_sample (rd_sample),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

[sv/mpo_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpo_front: command decode and sample generation
// Takes one word at a time, handles start, stop and table loads, and for a
// frame tick while running works the phase into one sample over a short
// sequence of steps, then pushes it into the word queue (zero when stopped).
// ----------------------------------------------------------------------------
module mpo_front #(
    parameter int TABLE_DEPTH        = mpo_pkg::DEF_TABLE_DEPTH,
    parameter int SINE_QUARTER_DEPTH = mpo_pkg::DEF_SINE_QUARTER_DEPTH,
    parameter int PHASE_BITS         = mpo_pkg::DEF_PHASE_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mpo_pkg::cfg_t      cfg,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  mpo_pkg::op_t       operation,
    input  logic [31:0]        phase_step,
    input  logic [10:0]        table_index,
    input  logic signed [15:0] table_value,
    output mpo_pkg::q_push_t   push,
    input  mpo_pkg::q_stat_t   q_stat
);
    import mpo_pkg::*;

    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SZW = $clog2(TABLE_DEPTH + 1);
    localparam int SQW = $clog2(SINE_QUARTER_DEPTH + 1);

    typedef logic [15:0] sine_rom_t [SINE_QUARTER_DEPTH + 1];

    function automatic sine_rom_t build_sine();
        sine_rom_t         rom;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        longint            v;
        for (int k = 0; k <= SINE_QUARTER_DEPTH; k++)
        begin
            x = (64'(k) * HALF_PI_Q30 + 64'(SINE_QUARTER_DEPTH / 2)) / SINE_QUARTER_DEPTH;
            x2 = (x * x) >> 30;
            term = x;
            sum = signed'(x);
            for (int n = 1; n <= 7; n++)
            begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n - 1];
                if ((n % 2) == 1)
                    sum = sum - signed'(term);
                else
                    sum = sum + signed'(term);
            end
            if (sum < 0)
                sum = 0;
            v = signed'((unsigned'(sum) * 64'd32767 + 64'd536870912) >> 30);
            if (v > 32767)
                v = 32767;
            rom[k] = v[15:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine();

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_READ,
        ST_MAC,
        ST_SUM,
        ST_PUSH
    } state_t;

    state_t                  state_reg;
    logic                    ready_reg;
    logic                    running_reg;
    logic [PHASE_BITS-1:0]   phase_reg;

    logic [31:0]             p_reg;
    logic [30+SQW-1:0]       sine_prod_reg;
    logic [32+SZW-1:0]       pos_reg;
    logic [15:0]             rom_q_reg;
    logic signed [15:0]      a_reg;
    logic signed [15:0]      b_reg;
    logic [15:0]             f_reg;
    logic signed [33:0]      wa_reg;
    logic signed [33:0]      wb_reg;
    logic signed [15:0]      sample_reg;

    logic signed [15:0]      table_mem [TABLE_DEPTH];

    logic                    accept;
    logic [PHASE_BITS+31:0]  phase_wide;
    logic [PHASE_BITS+31:0]  step_wide;
    logic [31:0]             p_now;
    logic [PHASE_BITS-1:0]   inc;
    logic [SQW-1:0]          sine_i;
    logic [SQW-1:0]          sine_addr;
    logic [SZW-1:0]          size;
    logic [AW-1:0]           i0;
    logic [SZW-1:0]          i0_plus;
    logic [AW-1:0]           i1;
    logic [16:0]             f_inv;
    logic signed [35:0]      mix;
    logic signed [17:0]      tri_val;
    logic signed [15:0]      tri_sat;
    logic signed [15:0]      sine_val;
    logic signed [15:0]      shape_sample;
    logic                    load_hit;

    assign accept   = s_tvalid && ready_reg;
    assign s_tready = ready_reg;

    // phase as Q0.32 and step scaled to the accumulator width
    assign phase_wide = {phase_reg, 32'b0} >> PHASE_BITS;
    assign p_now      = phase_wide[31:0];
    assign step_wide  = {phase_step, {PHASE_BITS{1'b0}}} >> 32;
    assign inc        = step_wide[PHASE_BITS-1:0];

    assign sine_i    = sine_prod_reg[30 +: SQW];
    assign sine_addr = p_reg[30] ? (SQW'(SINE_QUARTER_DEPTH) - sine_i) : sine_i;

    assign size    = (32'(cfg.table_size) > 32'(TABLE_DEPTH)) ? SZW'(TABLE_DEPTH)
                                                              : SZW'(cfg.table_size);
    assign i0      = AW'(pos_reg[32 +: SZW]);
    assign i0_plus = SZW'(i0) + SZW'(1);
    assign i1      = (i0_plus == size) ? '0 : AW'(i0_plus);

    assign f_inv = 17'h10000 - {1'b0, f_reg};
    assign mix   = 36'(wa_reg) + 36'(wb_reg) + 36'sd32768;

    assign tri_val = p_reg[31] ? (18'sd98304 - $signed({1'b0, p_reg[31:15]}))
                               : ($signed({2'b00, p_reg[30:15]}) - 18'sd32768);
    assign tri_sat = (tri_val > 18'sd32767) ? 16'sd32767 : 16'(tri_val);

    assign sine_val = p_reg[31] ? 16'(-$signed({1'b0, rom_q_reg})) : $signed(rom_q_reg);

    always_comb
    begin
        case (cfg.wave_shape)
            SHAPE_SINE:     shape_sample = sine_val;
            SHAPE_SQUARE:   shape_sample = p_reg[31] ? -16'sd32768 : 16'sd32767;
            SHAPE_SAWTOOTH: shape_sample = $signed({~p_reg[31], p_reg[30:16]});
            SHAPE_TRIANGLE: shape_sample = tri_sat;
            SHAPE_CUSTOM:   shape_sample = (size == '0) ? 16'sd0 : mix[31:16];
            default:        shape_sample = 16'sd0;
        endcase
    end

    assign load_hit = (state_reg == ST_IDLE) && accept && (operation == OP_LOAD)
                      && (32'(table_index) < 32'(TABLE_DEPTH));

    assign push.valid  = (state_reg == ST_PUSH) && !q_stat.full;
    assign push.sample = sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ready_reg   <= 1'b0;
            running_reg <= 1'b0;
            phase_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        ready_reg <= 1'b0;
                        case (operation)
                            OP_TICK:
                            begin
                                if (running_reg)
                                begin
                                    phase_reg <= phase_reg + inc;
                                    state_reg <= ST_MUL;
                                end
                                else
                                    state_reg <= ST_PUSH;
                            end
                            OP_START:
                            begin
                                phase_reg   <= '0;
                                running_reg <= 1'b1;
                            end
                            OP_STOP:
                                running_reg <= 1'b0;
                            default: ;
                        endcase
                    end
                    else
                        ready_reg <= 1'b1;
                end
                ST_MUL:  state_reg <= ST_READ;
                ST_READ: state_reg <= ST_MAC;
                ST_MAC:  state_reg <= ST_SUM;
                ST_SUM:  state_reg <= ST_PUSH;
                ST_PUSH:
                begin
                    if (!q_stat.full)
                    begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    p_reg      <= p_now;
                    sample_reg <= '0;
                end
            end
            ST_MUL:
            begin
                sine_prod_reg <= p_reg[29:0] * SQW'(SINE_QUARTER_DEPTH);
                pos_reg       <= p_reg * size;
            end
            ST_READ:
            begin
                rom_q_reg <= SINE_ROM[sine_addr];
                f_reg     <= pos_reg[31:16];
            end
            ST_MAC:
            begin
                wa_reg <= a_reg * $signed({1'b0, f_inv});
                wb_reg <= b_reg * $signed({1'b0, f_reg});
            end
            ST_SUM:
                sample_reg <= shape_sample;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_hit)
            table_mem[AW'(table_index)] <= table_value;
        if (state_reg == ST_READ)
        begin
            a_reg <= table_mem[i0];
            b_reg <= table_mem[i1];
        end
    end

endmodule

[sv/mpo_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpo_queue: sample word queue
// Short first-in first-out store between the front end and the back end.
// ----------------------------------------------------------------------------
module mpo_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  mpo_pkg::q_push_t   push,
    input  logic               pop,
    output mpo_pkg::q_stat_t   q_stat,
    output logic signed [15:0] rd_sample
);
    import mpo_pkg::*;

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic signed [15:0] store_reg [QUEUE_DEPTH];
    logic [QW-1:0]      wr_ptr_reg;
    logic [QW-1:0]      rd_ptr_reg;
    logic [QW:0]        count_reg;

    assign q_stat.full  = (count_reg == (QW+1)'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign rd_sample    = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.valid)
            store_reg[wr_ptr_reg] <= push.sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= (wr_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QW'(1);
            if (push.valid && !pop)
                count_reg <= count_reg + (QW+1)'(1);
            else if (pop && !push.valid)
                count_reg <= count_reg - (QW+1)'(1);
        end
    end

endmodule

[sv/mpo_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpo_back: channel fan-out
// Takes one sample from the queue and sends it once per channel, marking
// the final copy of the frame.
// ----------------------------------------------------------------------------
module mpo_back #(
    parameter int MAX_CHANNELS = mpo_pkg::DEF_MAX_CHANNELS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mpo_pkg::cfg_t      cfg,
    input  mpo_pkg::q_stat_t   q_stat,
    input  logic signed [15:0] rd_sample,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,   // sample_value[15:0], channel_index[18:16]
    output logic               m_tlast    // last_of_frame
);
    import mpo_pkg::*;

    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS + 1) : 1;

    logic               m_tvalid_reg;
    logic [CW-1:0]      ch_reg;
    logic signed [15:0] sample_reg;

    logic [CW-1:0]      n_ch;
    logic               last;

    assign n_ch = (cfg.channel_count == 4'd0) ? CW'(1) :
                  (32'(cfg.channel_count) > 32'(MAX_CHANNELS)) ? CW'(MAX_CHANNELS) :
                  CW'(cfg.channel_count);
    assign last = ((ch_reg + CW'(1)) == n_ch);
    assign pop  = !m_tvalid_reg && !q_stat.empty;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, 3'(ch_reg), sample_reg};
    assign m_tlast  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            ch_reg       <= '0;
        end
        else if (!m_tvalid_reg)
        begin
            if (!q_stat.empty)
            begin
                m_tvalid_reg <= 1'b1;
                ch_reg       <= '0;
            end
        end
        else if (m_tready)
        begin
            if (last)
                m_tvalid_reg <= 1'b0;
            else
                ch_reg <= ch_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            sample_reg <= rd_sample;
    end

endmodule

[sv/mpo_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpo_checker: port-level checks for the oscillator
// Watches the stream ports for reset state, input pacing, channel order
// within a frame and output word stability.
// ----------------------------------------------------------------------------
module mpo_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    logic [2:0] exp_ch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            exp_ch_reg <= 3'd0;
        else if (m_tvalid && m_tready)
            exp_ch_reg <= m_tlast ? 3'd0 : m_tdata[18:16] + 3'd1;
    end

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> (!s_tready && !m_tvalid))
        else $error("ready or valid high during reset");

    a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken on two consecutive cycles");

    a_channel_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) |-> (m_tdata[18:16] == exp_ch_reg))
        else $error("channel copies out of order");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled output word changed");

endmodule

bind multiwave_phase_oscillator_unit mpo_checker u_mpo_checker (.*);
